[rtl/core/id3_text_to_utf8_unit_assert.svh]
// Assertion helpers for the checker of this block.
`ifndef ID3_TEXT_TO_UTF8_UNIT_ASSERT_SVH
`define ID3_TEXT_TO_UTF8_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I3U_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define I3U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/core/i3u_pkg.sv]
`timescale 1ns / 1ps
package i3u_pkg;

  localparam int PayloadLimit = 256;
  localparam int PayloadCntW  = $clog2(PayloadLimit + 1);
  localparam int CapW         = 10;
  localparam int RunMax       = 4;
  localparam int RunCntW      = 3;

  // encoding selector codes
  localparam logic [7:0] EncLatin1   = 8'd0;
  localparam logic [7:0] EncUtf16Bom = 8'd1;
  localparam logic [7:0] EncUtf16Be  = 8'd2;
  localparam logic [7:0] EncUtf8     = 8'd3;

  localparam logic [7:0]  Lead2   = 8'hC0;
  localparam logic [7:0]  Lead3   = 8'hE0;
  localparam logic [7:0]  ContTag = 8'h80;
  localparam logic [7:0]  BomHi   = 8'hFE;
  localparam logic [7:0]  BomLo   = 8'hFF;
  localparam logic [15:0] Lim1    = 16'h0080;
  localparam logic [15:0] Lim2    = 16'h0800;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
  } enc_res_t;

endpackage

[rtl/core/i3u_if.sv]
`timescale 1ns / 1ps
interface i3u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_last;
  modport source (output valid, in_byte, frame_last, input ready);
  modport sink   (input valid, in_byte, frame_last, output ready);
endinterface

interface i3u_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;
  logic       run_last;
  modport source (output valid, out_byte, is_terminator, run_last, input ready);
  modport sink   (input valid, out_byte, is_terminator, run_last, output ready);
endinterface

interface i3u_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] text_capacity;
  modport source (output valid, text_capacity, input ready);
  modport sink   (input valid, text_capacity, output ready);
endinterface

[rtl/core/id3_text_to_utf8_unit.sv]
`timescale 1ns / 1ps
// ID3 text frame to UTF-8 converter. Frame bytes arrive one request at a time on
// in_if; the first byte of a frame picks the encoding (0 Latin-1, 1 UTF-16 with
// optional BOM, little-endian by default, 2 UTF-16 big-endian, 3 raw copy, any
// other value yields empty text). Each request produces 0..4 results on out_if:
// up to three UTF-8 bytes and, on the byte flagged frame_last, a zero terminator
// with is_terminator set; run_last marks the final result of a request.
// Characters that would exceed text_capacity (cfg_if, reset 63) are dropped
// whole, payload beyond 256 bytes is ignored, a UTF-16 zero unit stops the text.
// Timing: a request is registered at the input, converted in one pass into a
// result buffer, and drained at one result per cycle while out_if is ready; the
// single output port sets that rate. The next request waits in the input
// register and is converted as the last previous result is taken. No clearing pass.
// Write text_capacity only while the block is idle.
module id3_text_to_utf8_unit import i3u_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  i3u_in_if.sink    in_if,
  i3u_out_if.source out_if,
  i3u_cfg_if.sink   cfg_if
);

  // configuration
  logic [CapW-1:0] cap_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(63);
    end else if (cfg_if.valid) begin
      cap_q <= cfg_if.text_capacity;
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_adv;

  assign in_if.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_q <= in_if.in_byte;
      s1_last_q <= in_if.frame_last;
    end
  end

  // frame state
  logic                   await_q, await_d;
  logic [7:0]             enc_q, enc_d;
  logic [PayloadCntW-1:0] pcnt_q, pcnt_d;
  logic [CapW-1:0]        emitted_q, emitted_d;
  logic [7:0]             held_q, held_d;
  logic                   half_q, half_d;
  logic                   le_q, le_d;
  logic                   halted_q, halted_d;

  logic        enc_en;
  logic        enc_raw;
  logic [15:0] enc_ch;
  logic [15:0] word;
  logic        term;
  enc_res_t    enc_res;

  i3u_char_enc u_char_enc (
    .en_i      (enc_en),
    .raw_i     (enc_raw),
    .ch_i      (enc_ch),
    .emitted_i (emitted_q),
    .cap_i     (cap_q),
    .res_o     (enc_res)
  );

  assign word = le_q ? {s1_byte_q, held_q} : {held_q, s1_byte_q};

  always_comb begin
    await_d   = await_q;
    enc_d     = enc_q;
    pcnt_d    = pcnt_q;
    emitted_d = emitted_q;
    held_d    = held_q;
    half_d    = half_q;
    le_d      = le_q;
    halted_d  = halted_q;
    enc_en    = 1'b0;
    enc_raw   = 1'b0;
    enc_ch    = {8'h00, s1_byte_q};
    term      = 1'b0;

    if (s1_adv) begin
      if (await_q) begin
        // selector byte: start a new frame
        await_d   = 1'b0;
        enc_d     = s1_byte_q;
        pcnt_d    = '0;
        emitted_d = '0;
        held_d    = '0;
        half_d    = 1'b0;
        halted_d  = 1'b0;
        le_d      = (s1_byte_q != EncUtf16Be);
      end else if (pcnt_q < PayloadCntW'(PayloadLimit)) begin
        pcnt_d = pcnt_q + PayloadCntW'(1);
        case (enc_q)
          EncUtf8: begin
            enc_en  = 1'b1;
            enc_raw = 1'b1;
          end
          EncLatin1: begin
            enc_en = 1'b1;
          end
          EncUtf16Bom, EncUtf16Be: begin
            if (!halted_q) begin
              if (!half_q) begin
                held_d = s1_byte_q;
                half_d = 1'b1;
              end else begin
                half_d = 1'b0;
                if (enc_q == EncUtf16Bom && pcnt_q == PayloadCntW'(1) &&
                    held_q == BomHi && s1_byte_q == BomLo) begin
                  le_d = 1'b0;
                end else if (enc_q == EncUtf16Bom && pcnt_q == PayloadCntW'(1) &&
                             held_q == BomLo && s1_byte_q == BomHi) begin
                  le_d = 1'b1;
                end else if (word == 16'h0000) begin
                  halted_d = 1'b1;
                end else begin
                  enc_en = 1'b1;
                  enc_ch = word;
                end
              end
            end
          end
          default: ;  // unknown encoding: payload ignored
        endcase
        if (enc_en) begin
          emitted_d = emitted_q + CapW'(enc_res.n);
        end
      end
      if (s1_last_q) begin
        term    = 1'b1;
        await_d = 1'b1;
        half_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q   <= 1'b1;
      enc_q     <= '0;
      pcnt_q    <= '0;
      emitted_q <= '0;
      held_q    <= '0;
      half_q    <= 1'b0;
      le_q      <= 1'b1;
      halted_q  <= 1'b0;
    end else begin
      await_q   <= await_d;
      enc_q     <= enc_d;
      pcnt_q    <= pcnt_d;
      emitted_q <= emitted_d;
      held_q    <= held_d;
      half_q    <= half_d;
      le_q      <= le_d;
      halted_q  <= halted_d;
    end
  end

  // result buffer: one request's results, drained one per cycle while out_if is ready
  logic [RunMax-1:0][7:0] run_q;
  logic [RunMax-1:0][7:0] run_new;
  logic [RunCntW-1:0]     run_n_q;
  logic [RunCntW-1:0]     run_n_new;
  logic [1:0]             run_pos_q;
  logic                   run_term_q;
  logic                   last_pos;
  logic                   out_fire;
  logic                   run_free;

  always_comb begin
    run_new      = '0;
    run_new[0]   = enc_res.bytes[0];
    run_new[1]   = enc_res.bytes[1];
    run_new[2]   = enc_res.bytes[2];
    run_new[enc_res.n] = 8'h00;  // terminator slot after the text bytes
    run_n_new    = RunCntW'(enc_res.n) + RunCntW'(term);
  end

  assign last_pos = ({1'b0, run_pos_q} == run_n_q - RunCntW'(1));
  assign out_fire = out_if.valid && out_if.ready;
  assign run_free = (run_n_q == '0) || (out_fire && last_pos);
  assign s1_adv   = s1_valid_q && run_free;

  assign out_if.valid         = (run_n_q != '0);
  assign out_if.out_byte      = run_q[run_pos_q];
  assign out_if.run_last      = last_pos;
  assign out_if.is_terminator = run_term_q && last_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_n_q    <= '0;
      run_pos_q  <= '0;
      run_term_q <= 1'b0;
    end else if (run_free) begin
      run_pos_q <= '0;
      if (s1_adv) begin
        run_n_q    <= run_n_new;
        run_term_q <= term;
      end else begin
        run_n_q    <= '0;
        run_term_q <= 1'b0;
      end
    end else if (out_fire) begin
      run_pos_q <= run_pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      run_q <= run_new;
    end
  end

endmodule

[rtl/core/i3u_char_enc.sv]
`timescale 1ns / 1ps
module i3u_char_enc import i3u_pkg::*; (
  input  logic            en_i,
  input  logic            raw_i,
  input  logic [15:0]     ch_i,
  input  logic [CapW-1:0] emitted_i,
  input  logic [CapW-1:0] cap_i,
  output enc_res_t        res_o
);

  logic [1:0]    len;
  logic [CapW:0] need;

  always_comb begin
    if (raw_i || ch_i < Lim1) begin
      len = 2'd1;
    end else if (ch_i < Lim2) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    need = {1'b0, emitted_i} + (CapW+1)'(len);

    res_o = '0;
    if (en_i && need <= {1'b0, cap_i}) begin
      res_o.n = len;
      case (len)
        2'd1: begin
          res_o.bytes[0] = ch_i[7:0];
        end
        2'd2: begin
          res_o.bytes[0] = Lead2 | {3'b000, ch_i[10:6]};
          res_o.bytes[1] = ContTag | {2'b00, ch_i[5:0]};
        end
        default: begin
          res_o.bytes[0] = Lead3 | {4'b0000, ch_i[15:12]};
          res_o.bytes[1] = ContTag | {2'b00, ch_i[11:6]};
          res_o.bytes[2] = ContTag | {2'b00, ch_i[5:0]};
        end
      endcase
    end
  end

endmodule

[rtl/core/i3u_checker.sv]
`timescale 1ns / 1ps
`include "id3_text_to_utf8_unit_assert.svh"
module i3u_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       is_terminator_i,
  input logic       run_last_i
);

  // a stalled result stays put
  `I3U_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(is_terminator_i) && $stable(run_last_i))
  // the terminator always closes its request's results
  `I3U_ASSERT_IMPL(a_term_last, clk_i, rst_ni, out_valid_i && is_terminator_i, run_last_i)
  // the terminator carries a zero byte
  `I3U_ASSERT_IMPL(a_term_zero, clk_i, rst_ni, out_valid_i && is_terminator_i, out_byte_i == 8'h00)

endmodule

bind id3_text_to_utf8_unit i3u_checker u_i3u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_byte_i      (out_if.out_byte),
  .is_terminator_i (out_if.is_terminator),
  .run_last_i      (out_if.run_last)
);

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import i3u_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 150;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_term;
    logic       run_last;
  } utf8_res_t;

  // directed row; typed rows carry their own expected bytes, first byte in ob[23:16]
  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] ob;
  } dir_row_t;

  typedef enum logic [1:0] {RxOpen, RxCoin, RxMostly, RxSparse} rx_pattern_e;

  logic clk_i;
  logic rst_ni;

  i3u_in_if  in_if ();
  i3u_out_if out_if ();
  i3u_cfg_if cfg_if ();

  id3_text_to_utf8_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // transcoder state as seen by the predictor
  logic [9:0]  cap_now;
  logic        want_sel;
  logic [7:0]  enc_sel;
  int          pay_idx;
  int          text_len;
  logic [7:0]  held_lo;
  logic        half_held;
  logic        lsb_first;
  logic        text_stopped;

  utf8_res_t   step_out_q[$];
  utf8_res_t   utf8_due_q[$];
  dir_row_t    dir_q[$];
  logic [8:0]  frm_q[$];

  int fails;
  int checked;
  int items_sent;
  int frames_sent;
  int caps_used;
  int burst_left;
  int cyc;
  int hold_go;
  int hold_seen;
  int hold_left;
  int rx_left;
  rx_pattern_e rx_mode;
  utf8_res_t   got_exp;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one UTF-8 character, skipped whole when it does not fit the capacity
  function automatic void utf8_put(input logic [15:0] ch);
    if (ch < Lim1) begin
      if (text_len + 1 <= int'(cap_now)) begin
        step_out_q.push_back({ch[7:0], 1'b0, 1'b0});
        text_len += 1;
      end
    end else if (ch < Lim2) begin
      if (text_len + 2 <= int'(cap_now)) begin
        step_out_q.push_back({Lead2 | {3'b000, ch[10:6]}, 1'b0, 1'b0});
        step_out_q.push_back({ContTag | {2'b00, ch[5:0]}, 1'b0, 1'b0});
        text_len += 2;
      end
    end else begin
      if (text_len + 3 <= int'(cap_now)) begin
        step_out_q.push_back({Lead3 | {4'b0000, ch[15:12]}, 1'b0, 1'b0});
        step_out_q.push_back({ContTag | {2'b00, ch[11:6]}, 1'b0, 1'b0});
        step_out_q.push_back({ContTag | {2'b00, ch[5:0]}, 1'b0, 1'b0});
        text_len += 3;
      end
    end
  endfunction

  // results of one frame byte, into step_out_q (run_last set by the caller)
  function automatic void transcode_step(input logic [7:0] b, input logic last);
    logic [15:0] unit;
    step_out_q.delete();
    if (want_sel) begin
      want_sel     = 1'b0;
      enc_sel      = b;
      pay_idx      = 0;
      text_len     = 0;
      held_lo      = 8'h00;
      half_held    = 1'b0;
      text_stopped = 1'b0;
      lsb_first    = (b != EncUtf16Be);
    end else if (pay_idx < PayloadLimit) begin
      if (enc_sel == EncUtf8) begin
        if (text_len + 1 <= int'(cap_now)) begin
          step_out_q.push_back({b, 1'b0, 1'b0});
          text_len += 1;
        end
      end else if (enc_sel == EncLatin1) begin
        utf8_put({8'h00, b});
      end else if ((enc_sel == EncUtf16Bom || enc_sel == EncUtf16Be) && !text_stopped) begin
        if (!half_held) begin
          held_lo   = b;
          half_held = 1'b1;
        end else begin
          half_held = 1'b0;
          if (enc_sel == EncUtf16Bom && pay_idx == 1 && held_lo == BomHi && b == BomLo) begin
            lsb_first = 1'b0;
          end else if (enc_sel == EncUtf16Bom && pay_idx == 1 && held_lo == BomLo &&
                       b == BomHi) begin
            lsb_first = 1'b1;
          end else begin
            unit = lsb_first ? {b, held_lo} : {held_lo, b};
            if (unit == 16'h0000) text_stopped = 1'b1;
            else utf8_put(unit);
          end
        end
      end
      pay_idx++;
    end
    if (last) begin
      step_out_q.push_back({8'h00, 1'b1, 1'b0});
      want_sel  = 1'b1;
      half_held = 1'b0;
    end
  endfunction

  // offer one request; bursts with random gaps, now and then a full drain first
  task automatic send_req(input logic [7:0] b, input logic last, input logic typed,
                          input logic [1:0] n, input logic [23:0] ob);
    bit pause_all;
    int i;
    utf8_res_t r;
    pause_all = ($urandom_range(0, 59) == 0);
    if (burst_left == 0 || pause_all) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while (pause_all && utf8_due_q.size() != 0);
      if (burst_left == 0) begin
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      end
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.frame_last <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    transcode_step(b, last);
    if (typed) begin
      step_out_q.delete();
      for (i = 0; i < int'(n); i++) step_out_q.push_back({ob[23 - 8 * i -: 8], 1'b0, 1'b0});
      if (last) step_out_q.push_back({8'h00, 1'b1, 1'b0});
    end
    for (i = 0; i < step_out_q.size(); i++) begin
      r = step_out_q[i];
      r.run_last = (i == step_out_q.size() - 1);
      utf8_due_q.push_back(r);
    end
    items_sent++;
    if (last) frames_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // capacity is only written once the block has drained
  task automatic set_capacity(input logic [9:0] v);
    in_if.valid <= 1'b0;
    while (utf8_due_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.text_capacity <= v;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cap_now = v;
    caps_used++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one random frame into frm_q, mostly well formed
  function automatic void make_frame(input bit long_one);
    logic [7:0]  sel;
    logic [15:0] u;
    int          kind;
    int          n_pay;
    int          bom;
    bit          msb_order;
    frm_q.delete();
    kind = $urandom_range(0, 15);
    if (long_one) sel = $urandom_range(0, 1) ? EncLatin1 : EncUtf8;
    else if (kind < 4) sel = EncLatin1;
    else if (kind < 9) sel = EncUtf16Bom;
    else if (kind < 12) sel = EncUtf16Be;
    else if (kind < 14) sel = EncUtf8;
    else sel = 8'($urandom_range(4, 255));
    frm_q.push_back({1'b0, sel});
    if (!long_one && $urandom_range(0, 15) == 0) begin
      // selector only
    end else if (sel == EncUtf16Bom || sel == EncUtf16Be) begin
      msb_order = (sel == EncUtf16Be);
      if (sel == EncUtf16Bom) begin
        bom = $urandom_range(0, 2);
        if (bom == 1) begin
          frm_q.push_back({1'b0, BomHi});
          frm_q.push_back({1'b0, BomLo});
          msb_order = 1'b1;
        end else if (bom == 2) begin
          frm_q.push_back({1'b0, BomLo});
          frm_q.push_back({1'b0, BomHi});
        end
      end
      n_pay = $urandom_range(0, 6);
      repeat (n_pay) begin
        case ($urandom_range(0, 9))
          0, 1, 2: u = 16'($urandom_range(1, 127));
          3, 4:    u = 16'($urandom_range(128, 2047));
          5, 6:    u = 16'($urandom_range(2048, 65535));
          7:       u = 16'($urandom_range(16'hD800, 16'hDFFF));
          8:       u = 16'h0000;
          default: u = 16'($urandom);
        endcase
        if (msb_order) begin
          frm_q.push_back({1'b0, u[15:8]});
          frm_q.push_back({1'b0, u[7:0]});
        end else begin
          frm_q.push_back({1'b0, u[7:0]});
          frm_q.push_back({1'b0, u[15:8]});
        end
      end
      if ($urandom_range(0, 3) == 0) frm_q.push_back({1'b0, 8'($urandom)});
    end else begin
      n_pay = long_one ? $urandom_range(10, 14) : $urandom_range(0, 10);
      repeat (n_pay) frm_q.push_back({1'b0, pick_byte()});
    end
    frm_q[frm_q.size() - 1][8] = 1'b1;
  endfunction

  // receiver: changing stall patterns, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_pattern_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 80);
      end
      rx_left--;
      case (rx_mode)
        RxOpen:   out_if.ready <= 1'b1;
        RxCoin:   out_if.ready <= 1'($urandom_range(0, 1));
        RxMostly: out_if.ready <= ($urandom_range(0, 7) != 0);
        default:  out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (utf8_due_q.size() == 0) begin
        $error("unexpected result: out_byte %h is_terminator %b", out_if.out_byte,
               out_if.is_terminator);
        fails++;
      end else begin
        got_exp = utf8_due_q.pop_front();
        checked++;
        if (out_if.out_byte !== got_exp.out_byte) begin
          $error("out_byte: expected %h, got %h", got_exp.out_byte, out_if.out_byte);
          fails++;
        end
        if (out_if.is_terminator !== got_exp.is_term) begin
          $error("is_terminator: expected %b, got %b", got_exp.is_term, out_if.is_terminator);
          fails++;
        end
        if (out_if.run_last !== got_exp.run_last) begin
          $error("run_last: expected %b, got %b", got_exp.run_last, out_if.run_last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $error("timeout after %0d cycles, %0d results still due", cyc, utf8_due_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic dir(input logic [7:0] b, input logic last, input logic typed,
                     input logic [1:0] n, input logic [23:0] ob);
    dir_q.push_back({b, last, typed, n, ob});
  endtask

  initial begin
    int ph;
    int ph_items;
    logic [9:0] v;
    dir_row_t row;
    fails = 0; checked = 0; items_sent = 0; frames_sent = 0; caps_used = 0;
    burst_left = 0; cyc = 0; hold_go = 0; hold_seen = 0; hold_left = 0; rx_left = 0;
    rx_mode = RxOpen;
    in_if.valid = 1'b0; in_if.in_byte = 8'h00; in_if.frame_last = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.text_capacity = 10'd0;
    cap_now = 10'd63; want_sel = 1'b1; enc_sel = 8'h00; pay_idx = 0; text_len = 0;
    held_lo = 8'h00; half_held = 1'b0; lsb_first = 1'b1; text_stopped = 1'b0;
    rst_ni = 1'b0;

    // raw copy, zero byte stays an ordinary byte
    dir(EncUtf8,     1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'h00,       1'b0, 1'b1, 2'd1, 24'h000000);
    dir(8'hFF,       1'b1, 1'b1, 2'd1, 24'hFF0000);
    // Latin-1 widening at the one/two byte boundary
    dir(EncLatin1,   1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'h7F,       1'b0, 1'b1, 2'd1, 24'h7F0000);
    dir(8'h80,       1'b0, 1'b1, 2'd2, 24'hC28000);
    dir(8'hFF,       1'b1, 1'b1, 2'd2, 24'hC3BF00);
    // unknown selector that is also the last byte: terminator only
    dir(8'h05,       1'b1, 1'b1, 2'd0, 24'h000000);
    // big-endian BOM, a lone surrogate, U+FFFF, then a zero unit halts the text
    dir(EncUtf16Bom, 1'b0, 1'b1, 2'd0, 24'h000000);
    dir(BomHi,       1'b0, 1'b1, 2'd0, 24'h000000);
    dir(BomLo,       1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'hD8,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h00,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'hFF,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'hFF,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h00,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h00,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h41,       1'b1, 1'b0, 2'd0, 24'h000000);
    // big-endian text with an odd trailing byte
    dir(EncUtf16Be,  1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'h00,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h41,       1'b0, 1'b0, 2'd0, 24'h000000);
    dir(8'h07,       1'b1, 1'b0, 2'd0, 24'h000000);
    // unknown encoding with payload gives empty text
    dir(8'hFF,       1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'h12,       1'b0, 1'b1, 2'd0, 24'h000000);
    dir(8'h00,       1'b1, 1'b1, 2'd0, 24'h000000);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) begin
      row = dir_q[i];
      send_req(row.b, row.last, row.typed, row.n, row.ob);
    end

    // random phases across capacity settings, extremes first
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       v = 10'd0;
        1:       v = 10'd1023;
        2:       v = 10'd1;
        3:       v = 10'd2;
        4:       v = 10'd3;
        5:       v = 10'($urandom_range(4, 24));
        6:       v = 10'($urandom_range(0, 1023));
        default: v = 10'd63;
      endcase
      set_capacity(v);
      if (ph == 1) begin
        // longer frame while the receiver holds off, so the block backs up
        hold_go++;
        make_frame(1'b1);
        foreach (frm_q[i]) send_req(frm_q[i][7:0], frm_q[i][8], 1'b0, 2'd0, 24'h0);
      end
      ph_items = 0;
      while (ph_items < 14) begin
        make_frame(1'b0);
        foreach (frm_q[i]) send_req(frm_q[i][7:0], frm_q[i][8], 1'b0, 2'd0, 24'h0);
        ph_items += frm_q.size();
      end
    end

    in_if.valid <= 1'b0;
    while (utf8_due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests in %0d frames under %0d capacity settings (0 and 1023 incl.),",
             items_sent, frames_sent, caps_used);
    $display("checked %0d UTF-8 result bytes incl. terminators; %0d mismatches.",
             checked, fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
